### rtl/bkin_pkg.sv
package bkin_pkg;

  localparam int POSITION_WIDTH_DEF  = 32;
  localparam int TRIG_ITERATIONS_DEF = 16;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 144;
  localparam int TRIG_W = 34;   // CORDIC x/y/z, Q2.30 with headroom
  localparam int DIV_W  = 64;   // dividend / quotient
  localparam int DVS_W  = 33;   // divisor
  localparam int MUL_W  = 48;   // shared multiplier operand width
  localparam int ACC_W  = 96;

  localparam logic [14:0]              STEER_CAP    = 15'd24000;
  localparam logic signed [TRIG_W-1:0] CORDIC_SEED  = 34'sd652032874;
  localparam logic [MUL_W-1:0]         STEER_TO_BAM = 48'd10680708;
  localparam logic [MUL_W-1:0]         RAD_TO_BAM16 = 48'd2670177;
  localparam logic [MUL_W-1:0]         MS_PER_S     = 48'd1000;

  typedef enum logic [2:0] {
    REG_WHEELBASE = 3'd0,
    REG_STEP_TIME = 3'd1,
    REG_MAX_SPEED = 3'd2,
    REG_MIN_SPEED = 3'd3,
    REG_STEER_LIM = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST, ST_BAM, ST_TRIG1, ST_PROD1, ST_DIV1, ST_SCALE,
    ST_DIV2, ST_TRIG2, ST_PX, ST_PY, ST_TIME, ST_DONE
  } st_t;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/bicycle_kinematics_step.sv
// Channel | Dir | Fields (tdata, lowest bit first)
// in_     | in  | speed_demand[15:0], steer_demand[31:16]
// out_    | out | pos_x[31:0], pos_y[63:32], heading[79:64], time_ms[111:80],
//         |     | steer_used[127:112], speed_used[143:128]
// cfg_    | in  | cfg_index selects register, cfg_data carries the value
//
// The two radix-2 divisions dominate a tick, then the two CORDIC passes, then
// seven passes through the shared 48x16 multiplier.
// Reset (rst_n low, synchronous) restores register defaults and zeroes the
// pose and clock. in_tready is high only while idle; a finished result waits
// in the output register while the next tick is accepted. cfg is always ready.
module bicycle_kinematics_step #(
  parameter int POSITION_WIDTH  = bkin_pkg::POSITION_WIDTH_DEF,
  parameter int TRIG_ITERATIONS = bkin_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bkin_pkg::IN_W-1:0]  in_tdata,   // speed_demand, steer_demand
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bkin_pkg::OUT_W-1:0] out_tdata,  // pos_x, pos_y, heading,
                                                 // time_ms, steer_used, speed_used
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data
);
  import bkin_pkg::*;

  localparam int PW = POSITION_WIDTH;

  st_t st_r, st_nxt;

  // config
  logic [15:0]        wb_r, step_r;
  logic signed [15:0] vmax_r, vmin_r;
  logic [14:0]        lim_r;

  // architectural state
  logic [15:0]   heading_r, heading_nxt;
  logic [PW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [47:0]   elapsed_r, elapsed_nxt;

  // per-tick working registers
  logic signed [15:0]       spd_r, spd_nxt, str_r, str_nxt;
  logic signed [32:0]       dist_r, dist_nxt;
  logic signed [TRIG_W-1:0] c1_r, c1_nxt, s1_r, s1_nxt, c2_r, c2_nxt, s2_r, s2_nxt;
  logic                     sdn_r, sdn_nxt;
  logic [MUL_W-1:0]         p_r, p_nxt;
  logic [31:0]              time_r, time_nxt;
  logic [OUT_W-1:0]         odata_r, odata_nxt;
  logic                     ovalid_r, ovalid_nxt;

  // shared multiplier
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  logic [1:0]              mcnt_r, mcnt_nxt;
  logic [MUL_W-1:0]        mul_a, mul_b;
  logic                    mul_neg, mul_st, mul_done;
  logic [15:0]             mul_chunk;
  logic [63:0]             mul_pp;
  logic signed [ACC_W-1:0] prod, rnd;

  // sub-units
  logic                     cs_start, cs_done;
  logic [31:0]              cs_ang;
  logic signed [TRIG_W-1:0] cs_cos, cs_sin;
  logic                     dv_start, dv_done;
  logic [DIV_W-1:0]         dv_dvd, dv_quot;
  logic [DVS_W-1:0]         dv_dvs;

  // intake clamp
  logic signed [15:0] in_spd, in_str, spd_c, str_c;
  logic signed [16:0] str17, lim17;
  logic [14:0]        lim_eff;

  logic signed [16:0] spd_abs;
  logic [15:0]        str_abs;
  logic [TRIG_W-1:0]  s1_abs, s2_abs, c2_abs;
  logic [32:0]        dist_abs;
  logic [31:0]        bam_mag, bam;
  logic [63:0]        dh, dh_rnd;
  logic [15:0]        head_new;
  logic [15:0]        wb_eff;
  logic [63:0]        x_ext, y_ext;
  logic               accept, load_out;

  // ---------------------------------------------------------------- intake
  always_comb begin
    in_spd  = $signed(in_tdata[15:0]);
    in_str  = $signed(in_tdata[31:16]);
    spd_c   = (in_spd > vmax_r) ? vmax_r : in_spd;    // max first, min wins
    spd_c   = (spd_c < vmin_r) ? vmin_r : spd_c;
    lim_eff = (lim_r > STEER_CAP) ? STEER_CAP : lim_r; // keeps tan finite
    lim17   = $signed({2'b0, lim_eff});
    str17   = 17'(in_str);
    str17   = (str17 > lim17) ? lim17 : str17;
    str17   = (str17 < -lim17) ? -lim17 : str17;
    str_c   = 16'(str17);
  end

  // ---------------------------------------------------------------- operands
  always_comb begin
    spd_abs  = spd_r[15] ? -17'(spd_r) : 17'(spd_r);
    str_abs  = str_r[15] ? 16'(-str_r) : 16'(str_r);
    s1_abs   = s1_r[TRIG_W-1] ? TRIG_W'(-s1_r) : TRIG_W'(s1_r);
    s2_abs   = s2_r[TRIG_W-1] ? TRIG_W'(-s2_r) : TRIG_W'(s2_r);
    c2_abs   = c2_r[TRIG_W-1] ? TRIG_W'(-c2_r) : TRIG_W'(c2_r);
    dist_abs = dist_r[32] ? 33'(-dist_r) : 33'(dist_r);
    wb_eff   = (wb_r == 16'd0) ? 16'd1 : wb_r;
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_tvalid) st_nxt = ST_DIST;
      ST_DIST:  if (mul_done) st_nxt = ST_BAM;
      ST_BAM:   if (mul_done) st_nxt = ST_TRIG1;
      ST_TRIG1: if (cs_done) st_nxt = ST_PROD1;
      ST_PROD1: if (mul_done) st_nxt = ST_DIV1;
      ST_DIV1:  if (dv_done) st_nxt = ST_SCALE;
      ST_SCALE: if (mul_done) st_nxt = ST_DIV2;
      ST_DIV2:  if (dv_done) st_nxt = ST_TRIG2;
      ST_TRIG2: if (cs_done) st_nxt = ST_PX;
      ST_PX:    if (mul_done) st_nxt = ST_PY;
      ST_PY:    if (mul_done) st_nxt = ST_TIME;
      ST_TIME:  if (mul_done) st_nxt = ST_DONE;
      ST_DONE:  if (!ovalid_r || out_tready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_st  = 1'b1;
    case (st_r)
      ST_DIST: begin
        mul_a   = MUL_W'(unsigned'(spd_abs));
        mul_b   = MUL_W'(step_r);
        mul_neg = spd_r[15];
      end
      ST_BAM: begin
        mul_a = MUL_W'(str_abs);
        mul_b = STEER_TO_BAM;
      end
      ST_PROD1: begin
        mul_a   = MUL_W'(s1_abs);
        mul_b   = MUL_W'(dist_abs);
        mul_neg = s1_r[TRIG_W-1] ^ dist_r[32];
      end
      ST_SCALE: begin
        mul_a = p_r;
        mul_b = RAD_TO_BAM16;
      end
      ST_PX: begin
        mul_a   = MUL_W'(s2_abs);
        mul_b   = MUL_W'(dist_abs);
        mul_neg = s2_r[TRIG_W-1] ^ dist_r[32];
      end
      ST_PY: begin
        mul_a   = MUL_W'(c2_abs);
        mul_b   = MUL_W'(dist_abs);
        mul_neg = c2_r[TRIG_W-1] ^ dist_r[32];
      end
      ST_TIME: begin
        mul_a = elapsed_r;
        mul_b = MS_PER_S;
      end
      default: mul_st = 1'b0;
    endcase

    // 16 bits of b per cycle, three passes
    mul_done  = mul_st && (mcnt_r == 2'd3);
    mul_chunk = 16'(mul_b >> {mcnt_r, 4'b0});
    mul_pp    = {16'b0, mul_a} * {48'b0, mul_chunk};
    prod      = mul_neg ? -$signed(acc_r) : $signed(acc_r);
    rnd       = (prod + (96'sd1 <<< 37)) >>> 38;

    // steer to binary angle
    bam_mag = prod[39:8];
    bam     = str_r[15] ? -bam_mag : bam_mag;

    // heading increment, rounded half up
    dh       = sdn_r ? -dv_quot : dv_quot;
    dh_rnd   = dh + (64'd1 << 23);
    head_new = heading_r + dh_rnd[39:24];

    cs_start = (st_r == ST_BAM && mul_done) || (st_r == ST_DIV2 && dv_done);
    cs_ang   = (st_r == ST_BAM) ? bam : {head_new, 16'h0};

    dv_start = (st_r == ST_PROD1 || st_r == ST_SCALE) && mul_done;
    dv_dvd   = acc_r[DIV_W-1:0];
    dv_dvs   = (st_r == ST_PROD1) ? DVS_W'(c1_r) : DVS_W'(wb_eff);

    accept   = (st_r == ST_IDLE) && in_tvalid;
    load_out = (st_r == ST_DONE) && (!ovalid_r || out_tready);

    in_tready  = (st_r == ST_IDLE);
    out_tvalid = ovalid_r;
    out_tdata  = odata_r;
    cfg_ready  = 1'b1;
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    acc_nxt     = acc_r;
    mcnt_nxt    = mcnt_r;
    spd_nxt     = spd_r;
    str_nxt     = str_r;
    dist_nxt    = dist_r;
    c1_nxt      = c1_r;
    s1_nxt      = s1_r;
    c2_nxt      = c2_r;
    s2_nxt      = s2_r;
    sdn_nxt     = sdn_r;
    p_nxt       = p_r;
    heading_nxt = heading_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    elapsed_nxt = elapsed_r;
    time_nxt    = time_r;
    odata_nxt   = odata_r;
    ovalid_nxt  = ovalid_r;
    x_ext       = 64'(x_r);
    y_ext       = 64'(y_r);

    if (mul_st) begin
      if (mul_done) begin
        acc_nxt  = '0;
        mcnt_nxt = '0;
      end else begin
        acc_nxt  = acc_r + (ACC_W'(mul_pp) << {mcnt_r, 4'b0});
        mcnt_nxt = mcnt_r + 2'd1;
      end
    end

    if (accept) begin
      spd_nxt = spd_c;
      str_nxt = str_c;
    end
    if (st_r == ST_DIST && mul_done) dist_nxt = 33'(prod);
    if (st_r == ST_TRIG1 && cs_done) begin
      c1_nxt = (cs_cos < 34'sd1) ? 34'sd1 : cs_cos;  // degenerate cosine
      s1_nxt = cs_sin;
    end
    if (st_r == ST_PROD1 && mul_done) sdn_nxt = mul_neg;
    if (st_r == ST_DIV1 && dv_done) p_nxt = dv_quot[MUL_W-1:0];
    if (st_r == ST_DIV2 && dv_done) heading_nxt = head_new;
    if (st_r == ST_TRIG2 && cs_done) begin
      c2_nxt = cs_cos;
      s2_nxt = cs_sin;
    end
    if (st_r == ST_PX && mul_done) x_nxt = x_r - PW'(rnd);
    if (st_r == ST_PY && mul_done) begin
      y_nxt       = y_r + PW'(rnd);
      elapsed_nxt = elapsed_r + 48'(step_r);
    end
    if (st_r == ST_TIME && mul_done) time_nxt = prod[47:16];

    if (load_out) begin
      odata_nxt  = {spd_r, str_r, time_r, heading_r, y_ext[31:0], x_ext[31:0]};
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      ovalid_r  <= 1'b0;
      acc_r     <= '0;
      mcnt_r    <= '0;
      heading_r <= '0;
      x_r       <= '0;
      y_r       <= '0;
      elapsed_r <= '0;
      wb_r      <= 16'd1024;
      step_r    <= 16'd2621;
      vmax_r    <= 16'sd2560;
      vmin_r    <= -16'sd2560;
      lim_r     <= 15'd11469;
    end else begin
      st_r      <= st_nxt;
      ovalid_r  <= ovalid_nxt;
      acc_r     <= acc_nxt;
      mcnt_r    <= mcnt_nxt;
      heading_r <= heading_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      elapsed_r <= elapsed_nxt;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_WHEELBASE: wb_r   <= cfg_data;
          REG_STEP_TIME: step_r <= cfg_data;
          REG_MAX_SPEED: vmax_r <= $signed(cfg_data);
          REG_MIN_SPEED: vmin_r <= $signed(cfg_data);
          REG_STEER_LIM: lim_r  <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    spd_r   <= spd_nxt;
    str_r   <= str_nxt;
    dist_r  <= dist_nxt;
    c1_r    <= c1_nxt;
    s1_r    <= s1_nxt;
    c2_r    <= c2_nxt;
    s2_r    <= s2_nxt;
    sdn_r   <= sdn_nxt;
    p_r     <= p_nxt;
    time_r  <= time_nxt;
    odata_r <= odata_nxt;
  end

  bkin_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .ang   (cs_ang),
    .done  (cs_done),
    .cos_o (cs_cos),
    .sin_o (cs_sin)
  );

  bkin_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_dvs),
    .done     (dv_done),
    .quot     (dv_quot)
  );

endmodule

### rtl/bkin_cordic.sv
module bkin_cordic #(
  parameter int ITER = bkin_pkg::TRIG_ITERATIONS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [31:0]                        ang,
  output logic                               done,
  output logic signed [bkin_pkg::TRIG_W-1:0] cos_o,
  output logic signed [bkin_pkg::TRIG_W-1:0] sin_o
);
  import bkin_pkg::*;

  localparam int IW = $clog2(ITER);

  logic                     busy_r, done_r, flip_r;
  logic [IW-1:0]            i_r;
  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic signed [TRIG_W-1:0] xs, ys, at;
  logic                     flip;
  logic [31:0]              ang_f;

  // angles in [90, 270) deg are turned by 180 deg first
  always_comb begin
    flip  = ang[31] ^ ang[30];
    ang_f = {ang[31] ^ flip, ang[30:0]};
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    at    = $signed({4'b0, atan_bam(5'(i_r))});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        if (i_r == IW'(ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_SEED;
      y_r    <= '0;
      z_r    <= TRIG_W'($signed(ang_f));
      flip_r <= flip;
    end else if (busy_r) begin
      if (!z_r[TRIG_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

### rtl/bkin_div.sv
module bkin_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bkin_pkg::DIV_W-1:0] dividend,
  input  logic [bkin_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [bkin_pkg::DIV_W-1:0] quot
);
  import bkin_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic             busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W-1:0] rem_r, dvs_r;
  logic [DIV_W-1:0] q_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, q_r[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

### sim/bicycle_kinematics_step_tb.sv
module bicycle_kinematics_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bkin_pkg::*;

  // Each transfer waits for a whole tick plus sender gaps and receiver stalls.
  // 1900 ticks with such gaps and stalls stay well below this limit.
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     TICK_LAT    = 260;
  localparam int     N_RANDOM    = 1900;

  typedef struct packed {
    logic        [15:0] speed_used;
    logic        [15:0] steer_used;
    logic        [31:0] time_ms;
    logic signed [15:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } pose_t;

  // Software copy of the vehicle: registers plus accumulated pose.
  class pose_tracker;
    logic [15:0] wheelbase, dt;
    logic [15:0] vmax, vmin;
    logic [14:0] steer_lim;
    logic [15:0] hdg;
    logic [31:0] px, py;
    logic [47:0] clock_acc;
    pose_t       pending[$];
    int          n_errors;
    int          n_checked;

    function void reset_state();
      wheelbase = 16'd1024;
      dt        = 16'd2621;
      vmax      = 16'd2560;
      vmin      = 16'hF600;
      steer_lim = 15'd11469;
      hdg       = '0;
      px        = '0;
      py        = '0;
      clock_acc = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] v);
      case (idx)
        REG_WHEELBASE: wheelbase = v;
        REG_STEP_TIME: dt        = v;
        REG_MAX_SPEED: vmax      = v;
        REG_MIN_SPEED: vmin      = v;
        REG_STEER_LIM: steer_lim = v[14:0];
        default: ;
      endcase
    endfunction

    static function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    // Rotation-mode CORDIC on a 32-bit binary angle, Q2.30 outputs.
    static function void rotate(logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, t;
      logic   turn;
      logic [31:0] a;
      longint atans[24];
      atans = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215,
                2608, 1304, 652, 326, 163, 81};
      a = ang;
      turn = a[31] ^ a[30];
      if (turn) a = a - 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'($signed(a));
      for (int i = 0; i < TRIG_ITERATIONS_DEF; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atans[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atans[i];
        end
        x = t;
      end
      c = turn ? -x : x;
      s = turn ? -y : y;
    endfunction

    // Note an accepted tick and queue the pose it must produce.
    function void note_tick(logic [15:0] spd_in, logic [15:0] str_in);
      longint spd, str, lim, wb, travel, mag, c, s, p, q, dh, dx, dy;
      logic [31:0] bam;
      logic [63:0] ms;
      pose_t r;
      spd = longint'($signed(spd_in));
      str = longint'($signed(str_in));
      lim = longint'(steer_lim);
      wb  = (wheelbase == 0) ? 1 : longint'(wheelbase);
      // max clamp first, so min wins when the clamps cross
      if (spd > longint'($signed(vmax))) spd = longint'($signed(vmax));
      if (spd < longint'($signed(vmin))) spd = longint'($signed(vmin));
      if (lim > 24000) lim = 24000;
      if (str > lim) str = lim;
      if (str < -lim) str = -lim;
      travel = spd * longint'(dt);
      mag = (str < 0) ? -str : str;
      bam = 32'((mag * 10680708) >> 8);
      if (str < 0) bam = -bam;
      rotate(bam, c, s);
      if (c < 1) c = 1;
      p = (s * travel) / c;
      q = p * 2670177;
      dh = q / wb;
      dh = floor_shr(dh + (longint'(1) << 23), 24);
      hdg = hdg + 16'(dh);
      rotate({hdg, 16'h0}, c, s);
      dx = -floor_shr(s * travel + (longint'(1) << 37), 38);
      dy = floor_shr(c * travel + (longint'(1) << 37), 38);
      px = px + 32'(dx);
      py = py + 32'(dy);
      clock_acc = clock_acc + 48'(dt);
      ms = (64'(clock_acc) * 64'd1000) >> 16;
      r.pos_x      = px;
      r.pos_y      = py;
      r.heading    = hdg;
      r.time_ms    = ms[31:0];
      r.steer_used = 16'(str);
      r.speed_used = 16'(spd);
      pending.push_back(r);
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: %h", got);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x expected %h actual %h", want.pos_x, got.pos_x); n_errors++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y expected %h actual %h", want.pos_y, got.pos_y); n_errors++;
      end
      if (got.heading !== want.heading) begin
        $error("heading expected %h actual %h", want.heading, got.heading); n_errors++;
      end
      if (got.time_ms !== want.time_ms) begin
        $error("time_ms expected %h actual %h", want.time_ms, got.time_ms); n_errors++;
      end
      if (got.steer_used !== want.steer_used) begin
        $error("steer_used expected %h actual %h", want.steer_used, got.steer_used);
        n_errors++;
      end
      if (got.speed_used !== want.speed_used) begin
        $error("speed_used expected %h actual %h", want.speed_used, got.speed_used);
        n_errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;   // speed_demand[15:0], steer_demand[31:16]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;       // pos_x, pos_y, heading, time_ms, steer, speed
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  pose_tracker model = new();
  longint      n_cycles = 0;
  int          n_cfg = 0;

  bicycle_kinematics_step u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // Result side: random stalls, checks every accepted transfer.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) model.check_pose(pose_t'(out_tdata));
      out_tready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               n_cycles, model.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // tvalid stays up after a transfer unless a gap follows; drain() drops it.
  task automatic send_tick(logic [15:0] spd, logic [15:0] str);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {str, spd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model.note_tick(spd, str);
  endtask

  // Only called once the block has drained.
  task automatic write_cfg(cfg_reg_t idx, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.write_reg(idx, v);
    n_cfg++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk);
    repeat (TICK_LAT) @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] wb, logic [15:0] dt, logic [15:0] vmax,
                         logic [15:0] vmin, logic [15:0] lim);
    drain();
    write_cfg(REG_WHEELBASE, wb);
    write_cfg(REG_STEP_TIME, dt);
    write_cfg(REG_MAX_SPEED, vmax);
    write_cfg(REG_MIN_SPEED, vmin);
    write_cfg(REG_STEER_LIM, lim);
  endtask

  // Random tick: mostly in-range demands so clamps and turning both show up.
  task automatic random_tick();
    logic [15:0] spd, str;
    spd = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                    : 16'($signed($urandom_range(0, 6000)) - 3000);
    str = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                    : 16'($signed($urandom_range(0, 30000)) - 15000);
    send_tick(spd, str);
  endtask

  initial begin
    model.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes at reset settings, including clamps both ways.
    send_tick(16'h7FFF, 16'h7FFF);
    send_tick(16'h8000, 16'h8000);
    send_tick(16'h0000, 16'h0000);
    send_tick(16'h0A00, 16'h2CCD);
    send_tick(16'hF600, 16'hD333);
    send_tick(16'h0100, 16'h0001);
    send_tick(16'hFFFF, 16'hFFFF);
    send_tick(16'h5555, 16'hAAAA);
    send_tick(16'hAAAA, 16'h5555);
    // Steering limit above the cap, zero wheelbase, full range speeds.
    set_all(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_tick(16'h7FFF, 16'h7FFF);
    send_tick(16'h8000, 16'h8000);
    send_tick(16'h1234, 16'h5DC0);
    // Crossed clamps: min wins; zero step time; zero steering limit.
    set_all(16'hFFFF, 16'h0000, 16'hFC00, 16'h0400, 16'h0000);
    send_tick(16'h7FFF, 16'h4000);
    send_tick(16'h8000, 16'hC000);
    // Out of range register index is ignored by the block.
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data  <= 16'hFFFF;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    send_tick(16'h0200, 16'h1000);

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_all(16'd1024, 16'd2621, 16'd2560, 16'hF600, 16'd11469);
        1: set_all(16'd1, 16'd65535, 16'h7FFF, 16'h8000, 16'd24000);
        2: set_all(16'd65535, 16'd1, 16'd256, 16'hFF00, 16'd1);
        default: set_all(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                         16'($urandom), 16'($urandom), 16'($urandom_range(0, 32767)));
      endcase
      repeat (N_RANDOM / 8) random_tick();
    end

    drain();
    $display("covered %0d ticks over %0d register writes, extremes and crossed clamps",
             model.n_checked, n_cfg);
    if (model.n_errors == 0 && model.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bkin_pkg.sv
rtl/bkin_cordic.sv
rtl/bkin_div.sv
rtl/bicycle_kinematics_step.sv
sim/bicycle_kinematics_step_tb.sv
